@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and tables of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uvs_pkg;

    localparam int MAX_RES_DEF       = 1024;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // restoring divider: one quotient bit per cell, quotient up to 2^32
    localparam int DIV_CELLS = 33;

    // CORDIC start value 0.607252935 in Q30
    localparam logic signed [33:0] KGAIN = 34'sd652032874;

    localparam logic [1:0] CFG_THETA  = 2'd0;
    localparam logic [1:0] CFG_PHI    = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic [2:0] KIND_POS  = 3'd0;
    localparam logic [2:0] KIND_NORM = 3'd1;
    localparam logic [2:0] KIND_TEX  = 3'd2;
    localparam logic [2:0] KIND_TAN  = 3'd3;
    localparam logic [2:0] KIND_BIN  = 3'd4;
    localparam logic [2:0] KIND_TRI  = 3'd5;
    localparam logic [2:0] KIND_INV  = 3'd6;

    typedef struct packed {
        logic       func;
        logic [9:0] ring;
        logic [9:0] segment;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
        logic               last;
    } t_out_beat;

    // item data that rides alongside the arithmetic
    typedef struct packed {
        logic        func;
        logic        bad;
        logic [20:0] base;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
    } t_side;

    typedef struct packed {
        logic [11:0] rem;
        logic [32:0] quo;
    } t_div_lane;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } t_rot_lane;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_res;

    typedef struct packed {
        logic [2:0] cnt;
        t_res [4:0] ent;
    } t_res_set;

    // arctangent of 2^-i in binary-angle units (2^32 per turn)
    function automatic logic signed [33:0] atan_val(input int idx);
        logic signed [33:0] v;
        case (idx)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/uv_sphere_vertex_generator.sv @@
// A vertex item (func 0) yields five beats (position, normal, texcoord, tangent,
// binormal), a quad item (func 1) two triangle beats and a rejected item one
// invalid beat. Items enter a pipeline of 39 + CORDIC_STAGES stages (a 33-cell
// divider chain for the angles, a CORDIC cell chain, four stages of products
// and rounding), one per cycle while the pipeline is not stalled; the single
// result port then hands out each item's beats one at a time, and the whole
// pipeline holds while a finished set waits for the serializer to be free. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// UV sphere mesh generator: vertex attributes and quad triangles per grid point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uv_sphere_vertex_generator #(
    parameter int MAX_RES       = uvs_pkg::MAX_RES_DEF,
    parameter int FRAC_BITS     = uvs_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = uvs_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  uvs_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output uvs_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int DC = uvs_pkg::DIV_CELLS;

    logic [10:0] r_theta_steps;
    logic [10:0] r_phi_steps;
    logic [23:0] r_radius;

    logic en;
    logic in_take;
    logic ser_free;
    logic tail_valid;
    uvs_pkg::t_res_set tail_set;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta_steps <= 11'd32;
            r_phi_steps   <= 11'd16;
            r_radius      <= 24'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                uvs_pkg::CFG_THETA:  r_theta_steps <= i_cfg_data[10:0];
                uvs_pkg::CFG_PHI:    r_phi_steps   <= i_cfg_data[10:0];
                uvs_pkg::CFG_RADIUS: r_radius      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // whole pipeline advances together; it holds only when the tail set
    // cannot move into the serializer
    assign en         = !tail_valid || ser_free;
    assign o_in_stall = !en;
    assign in_take    = i_in_valid && en;

    // ---------------- input stage: range checks ----------------
    logic        cfg_ok;
    logic        vtx_ok;
    logic        quad_ok;
    logic [10:0] ring_w;
    logic [10:0] seg_w;
    logic [10:0] div_t;
    logic [10:0] div_p;

    assign ring_w  = 11'(i_in_data.ring);
    assign seg_w   = 11'(i_in_data.segment);
    assign div_t   = r_theta_steps - 11'd1;
    assign div_p   = r_phi_steps - 11'd1;
    assign cfg_ok  = (r_theta_steps >= 11'd2) && (32'(r_theta_steps) <= 32'(MAX_RES)) &&
                     (r_phi_steps >= 11'd2) && (32'(r_phi_steps) <= 32'(MAX_RES));
    assign vtx_ok  = (ring_w < r_phi_steps) && (seg_w < r_theta_steps);
    assign quad_ok = (ring_w < div_p) && (seg_w < div_t);

    logic               r_s0_valid;
    uvs_pkg::t_side     r_s0_side;
    uvs_pkg::t_div_lane r_s0_lane_t;
    uvs_pkg::t_div_lane r_s0_lane_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side.func  <= i_in_data.func;
            r_s0_side.bad   <= !cfg_ok || (i_in_data.func ? !quad_ok : !vtx_ok);
            r_s0_side.base  <= 21'(r_theta_steps) * 21'(i_in_data.ring) +
                               21'(i_in_data.segment);
            r_s0_side.tex_u <= 32'd0;
            r_s0_side.tex_v <= 32'd0;
            r_s0_lane_t     <= '{rem: 12'(i_in_data.segment), quo: 33'd0};
            r_s0_lane_p     <= '{rem: 12'(i_in_data.ring), quo: 33'd0};
        end
    end

    // ---------------- divider chain: segment*2^32/(T-1), ring*2^32/(P-1) ----
    logic               dv_valid [0:DC];
    uvs_pkg::t_side     dv_side  [0:DC];
    uvs_pkg::t_div_lane dv_lt    [0:DC];
    uvs_pkg::t_div_lane dv_lp    [0:DC];

    assign dv_valid[0] = r_s0_valid;
    assign dv_side[0]  = r_s0_side;
    assign dv_lt[0]    = r_s0_lane_t;
    assign dv_lp[0]    = r_s0_lane_p;

    for (genvar g = 0; g < DC; g++) begin : g_div
        uvs_div_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (dv_valid[g]),
            .i_side   (dv_side[g]),
            .i_div_t  (div_t),
            .i_div_p  (div_p),
            .i_lane_t (dv_lt[g]),
            .i_lane_p (dv_lp[g]),
            .o_valid  (dv_valid[g+1]),
            .o_side   (dv_side[g+1]),
            .o_lane_t (dv_lt[g+1]),
            .o_lane_p (dv_lp[g+1])
        );
    end

    // ---------------- pre-rotation: fold to [-pi/2, pi/2), texcoords ----------
    function automatic uvs_pkg::t_rot_lane fold(input logic [31:0] a);
        logic               fl;
        logic [31:0]        a2;
        uvs_pkg::t_rot_lane o;
        fl     = a[31] ^ a[30];
        a2     = fl ? (a ^ 32'h8000_0000) : a;
        o.x    = uvs_pkg::KGAIN;
        o.y    = 34'sd0;
        o.z    = {{2{a2[31]}}, a2};
        o.flip = fl;
        return o;
    endfunction

    logic [32:0] q_t;
    logic [32:0] q_p;
    logic [33:0] tex_u_w;
    logic [33:0] tex_v_w;
    uvs_pkg::t_side n_pre_side;

    assign q_t = dv_lt[DC].quo;
    assign q_p = dv_lp[DC].quo;
    // round half up: (q + 2^(31-F)) >> (32-F)
    assign tex_u_w = (34'(q_t) + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    assign tex_v_w = (34'(q_p) + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    always_comb begin
        n_pre_side       = dv_side[DC];
        n_pre_side.tex_u = tex_u_w[31:0];
        n_pre_side.tex_v = tex_v_w[31:0];
    end

    logic               r_pre_valid;
    uvs_pkg::t_side     r_pre_side;
    uvs_pkg::t_rot_lane r_pre_lane_t;
    uvs_pkg::t_rot_lane r_pre_lane_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (en) begin
            r_pre_valid <= dv_valid[DC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_side   <= n_pre_side;
            r_pre_lane_t <= fold(q_t[31:0]);
            r_pre_lane_p <= fold(q_p[32:1]);
        end
    end

    // ---------------- CORDIC chain ----------------
    logic               cr_valid [0:CORDIC_STAGES];
    uvs_pkg::t_side     cr_side  [0:CORDIC_STAGES];
    uvs_pkg::t_rot_lane cr_lt    [0:CORDIC_STAGES];
    uvs_pkg::t_rot_lane cr_lp    [0:CORDIC_STAGES];

    assign cr_valid[0] = r_pre_valid;
    assign cr_side[0]  = r_pre_side;
    assign cr_lt[0]    = r_pre_lane_t;
    assign cr_lp[0]    = r_pre_lane_p;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        uvs_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (cr_valid[g]),
            .i_side   (cr_side[g]),
            .i_lane_t (cr_lt[g]),
            .i_lane_p (cr_lp[g]),
            .o_valid  (cr_valid[g+1]),
            .o_side   (cr_side[g+1]),
            .o_lane_t (cr_lt[g+1]),
            .o_lane_p (cr_lp[g+1])
        );
    end

    // ---------------- unfold ----------------
    logic signed [33:0] uf_ct, uf_st, uf_cp, uf_sp;

    assign uf_ct = cr_lt[CORDIC_STAGES].flip ? -cr_lt[CORDIC_STAGES].x : cr_lt[CORDIC_STAGES].x;
    assign uf_st = cr_lt[CORDIC_STAGES].flip ? -cr_lt[CORDIC_STAGES].y : cr_lt[CORDIC_STAGES].y;
    assign uf_cp = cr_lp[CORDIC_STAGES].flip ? -cr_lp[CORDIC_STAGES].x : cr_lp[CORDIC_STAGES].x;
    assign uf_sp = cr_lp[CORDIC_STAGES].flip ? -cr_lp[CORDIC_STAGES].y : cr_lp[CORDIC_STAGES].y;

    logic               r_post_valid;
    uvs_pkg::t_side     r_post_side;
    logic signed [31:0] r_post_ct, r_post_st, r_post_cp, r_post_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_valid <= 1'b0;
        end else if (en) begin
            r_post_valid <= cr_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_post_side <= cr_side[CORDIC_STAGES];
            r_post_ct   <= uf_ct[31:0];
            r_post_st   <= uf_st[31:0];
            r_post_cp   <= uf_cp[31:0];
            r_post_sp   <= uf_sp[31:0];
        end
    end

    // ---------------- attributes and output ----------------
    uvs_attr #(
        .FRAC_BITS (FRAC_BITS)
    ) u_attr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (r_post_valid),
        .i_side        (r_post_side),
        .i_ct          (r_post_ct),
        .i_st          (r_post_st),
        .i_cp          (r_post_cp),
        .i_sp          (r_post_sp),
        .i_radius      (r_radius),
        .i_theta_steps (r_theta_steps),
        .o_valid       (tail_valid),
        .o_set         (tail_set)
    );

    uvs_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (tail_valid && en),
        .i_set       (tail_set),
        .i_out_stall (i_out_stall),
        .o_free      (ser_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/core/uvs_div_cell.sv @@
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring-division cell: settles one quotient bit for each angle lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  uvs_pkg::t_side    i_side,
    input  logic [10:0]       i_div_t,
    input  logic [10:0]       i_div_p,
    input  uvs_pkg::t_div_lane i_lane_t,
    input  uvs_pkg::t_div_lane i_lane_p,
    output logic              o_valid,
    output uvs_pkg::t_side    o_side,
    output uvs_pkg::t_div_lane o_lane_t,
    output uvs_pkg::t_div_lane o_lane_p
);

    function automatic uvs_pkg::t_div_lane div_step(input uvs_pkg::t_div_lane l,
                                                    input logic [10:0] d);
        logic               ge;
        logic [11:0]        r;
        uvs_pkg::t_div_lane o;
        ge    = l.rem >= {1'b0, d};
        r     = ge ? l.rem - {1'b0, d} : l.rem;
        o.rem = {r[10:0], 1'b0};
        o.quo = {l.quo[31:0], ge};
        return o;
    endfunction

    logic               r_valid;
    uvs_pkg::t_side     r_side;
    uvs_pkg::t_div_lane r_lane_t;
    uvs_pkg::t_div_lane r_lane_p;
    uvs_pkg::t_div_lane n_lane_t;
    uvs_pkg::t_div_lane n_lane_p;

    assign n_lane_t = div_step(i_lane_t, i_div_t);
    assign n_lane_p = div_step(i_lane_p, i_div_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side   <= i_side;
            r_lane_t <= n_lane_t;
            r_lane_p <= n_lane_p;
        end
    end

    assign o_valid  = r_valid;
    assign o_side   = r_side;
    assign o_lane_t = r_lane_t;
    assign o_lane_p = r_lane_p;

endmodule

@@ rtl/core/uvs_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// One rotation-mode CORDIC iteration for the theta and phi lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  uvs_pkg::t_side     i_side,
    input  uvs_pkg::t_rot_lane i_lane_t,
    input  uvs_pkg::t_rot_lane i_lane_p,
    output logic               o_valid,
    output uvs_pkg::t_side     o_side,
    output uvs_pkg::t_rot_lane o_lane_t,
    output uvs_pkg::t_rot_lane o_lane_p
);

    localparam logic signed [33:0] ATAN = uvs_pkg::atan_val(IDX);

    function automatic uvs_pkg::t_rot_lane rot_step(input uvs_pkg::t_rot_lane l);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        uvs_pkg::t_rot_lane o;
        dx     = l.y >>> IDX;
        dy     = l.x >>> IDX;
        o.flip = l.flip;
        if (!l.z[33]) begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.z = l.z - ATAN;
        end else begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.z = l.z + ATAN;
        end
        return o;
    endfunction

    logic               r_valid;
    uvs_pkg::t_side     r_side;
    uvs_pkg::t_rot_lane r_lane_t;
    uvs_pkg::t_rot_lane r_lane_p;
    uvs_pkg::t_rot_lane n_lane_t;
    uvs_pkg::t_rot_lane n_lane_p;

    assign n_lane_t = rot_step(i_lane_t);
    assign n_lane_p = rot_step(i_lane_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side   <= i_side;
            r_lane_t <= n_lane_t;
            r_lane_p <= n_lane_p;
        end
    end

    assign o_valid  = r_valid;
    assign o_side   = r_side;
    assign o_lane_t = r_lane_t;
    assign o_lane_p = r_lane_p;

endmodule

@@ rtl/core/uvs_attr.sv @@
// ----------------------------------------------------------------------------
// uvs_attr
// Products, rounding and saturation that turn sines and cosines into the
// vertex attributes; also forms triangle and invalid result sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_attr #(
    parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  uvs_pkg::t_side     i_side,
    input  logic signed [31:0] i_ct,
    input  logic signed [31:0] i_st,
    input  logic signed [31:0] i_cp,
    input  logic signed [31:0] i_sp,
    input  logic [23:0]        i_radius,
    input  logic [10:0]        i_theta_steps,
    output logic               o_valid,
    output uvs_pkg::t_res_set  o_set
);

    localparam int SH_Q = 30 - FRAC_BITS;
    localparam int SH_R = 46 - FRAC_BITS;

    function automatic logic [31:0] rnd_sat(input logic signed [65:0] v, input int sh);
        logic signed [65:0] t;
        t = (v + (66'sd1 <<< (sh - 1))) >>> sh;
        if (t > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (t < -66'sd2147483648) begin
            return 32'h8000_0000;
        end
        return t[31:0];
    endfunction

    // stage A: Q60 products of the Q30 sines and cosines
    logic               r_a_valid;
    uvs_pkg::t_side     r_a_side;
    logic signed [31:0] r_a_ct, r_a_st, r_a_cp, r_a_sp;
    logic signed [63:0] r_a_stcp, r_a_ctcp, r_a_stsp, r_a_ctsp;

    // stage B: rounded back to Q30
    logic               r_b_valid;
    uvs_pkg::t_side     r_b_side;
    logic signed [31:0] r_b_ct, r_b_st, r_b_cp, r_b_sp;
    logic signed [33:0] r_b_bx, r_b_bz, r_b_psx, r_b_psz;
    logic signed [33:0] n_b_bx, n_b_bz, n_b_psx, n_b_psz;

    // stage C: normal and radius products
    logic               r_c_valid;
    uvs_pkg::t_side     r_c_side;
    logic signed [31:0] r_c_ct, r_c_st, r_c_sp;
    logic signed [33:0] r_c_bx, r_c_bz, r_c_psx, r_c_psz;
    logic signed [63:0] r_c_p1, r_c_p2;
    logic signed [56:0] r_c_px, r_c_pz;
    logic signed [57:0] r_c_py;

    logic signed [24:0] rad_s;
    logic signed [32:0] neg_cp;
    logic signed [65:0] ny_sum;
    logic signed [65:0] ny_q30;
    logic [31:0]        tri_b0, tri_b1, tri_bt, tri_bt1;
    uvs_pkg::t_res_set  n_set;

    assign n_b_bx  = 34'((r_a_stcp + 64'sd536870912) >>> 30);
    assign n_b_bz  = 34'((r_a_ctcp + 64'sd536870912) >>> 30);
    assign n_b_psx = 34'((r_a_stsp + 64'sd536870912) >>> 30);
    assign n_b_psz = 34'((r_a_ctsp + 64'sd536870912) >>> 30);

    assign rad_s  = $signed({1'b0, i_radius});
    assign neg_cp = -33'(r_b_cp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_a_ct   <= i_ct;
            r_a_st   <= i_st;
            r_a_cp   <= i_cp;
            r_a_sp   <= i_sp;
            r_a_stcp <= i_st * i_cp;
            r_a_ctcp <= i_ct * i_cp;
            r_a_stsp <= i_st * i_sp;
            r_a_ctsp <= i_ct * i_sp;

            r_b_side <= r_a_side;
            r_b_ct   <= r_a_ct;
            r_b_st   <= r_a_st;
            r_b_cp   <= r_a_cp;
            r_b_sp   <= r_a_sp;
            r_b_bx   <= n_b_bx;
            r_b_bz   <= n_b_bz;
            r_b_psx  <= n_b_psx;
            r_b_psz  <= n_b_psz;

            r_c_side <= r_b_side;
            r_c_ct   <= r_b_ct;
            r_c_st   <= r_b_st;
            r_c_sp   <= r_b_sp;
            r_c_bx   <= r_b_bx;
            r_c_bz   <= r_b_bz;
            r_c_psx  <= r_b_psx;
            r_c_psz  <= r_b_psz;
            r_c_p1   <= r_b_st * $signed(r_b_bx[31:0]);
            r_c_p2   <= r_b_ct * $signed(r_b_bz[31:0]);
            r_c_px   <= rad_s * $signed(r_b_psx[31:0]);
            r_c_py   <= rad_s * neg_cp;
            r_c_pz   <= rad_s * $signed(r_b_psz[31:0]);
        end
    end

    assign ny_sum = -(66'(r_c_p1) + 66'(r_c_p2));
    assign ny_q30 = (ny_sum + (66'sd1 <<< 29)) >>> 30;

    // base + T fits in 21 bits for every legal grid
    assign tri_b0  = 32'(r_c_side.base);
    assign tri_b1  = tri_b0 + 32'd1;
    assign tri_bt  = tri_b0 + 32'(i_theta_steps);
    assign tri_bt1 = tri_bt + 32'd1;

    always_comb begin
        n_set = '0;
        if (r_c_side.bad) begin
            n_set.cnt         = 3'd1;
            n_set.ent[0].kind = uvs_pkg::KIND_INV;
        end else if (r_c_side.func) begin
            n_set.cnt    = 3'd2;
            n_set.ent[0] = '{kind: uvs_pkg::KIND_TRI, x: tri_b0, y: tri_b1, z: tri_bt1};
            n_set.ent[1] = '{kind: uvs_pkg::KIND_TRI, x: tri_b0, y: tri_bt1, z: tri_bt};
        end else begin
            n_set.cnt    = 3'd5;
            n_set.ent[0] = '{kind: uvs_pkg::KIND_POS,
                             x: rnd_sat(66'(r_c_px), SH_R),
                             y: rnd_sat(66'(r_c_py), SH_R),
                             z: rnd_sat(66'(r_c_pz), SH_R)};
            n_set.ent[1] = '{kind: uvs_pkg::KIND_NORM,
                             x: rnd_sat(66'(r_c_psx), SH_Q),
                             y: rnd_sat(ny_q30, SH_Q),
                             z: rnd_sat(66'(r_c_psz), SH_Q)};
            n_set.ent[2] = '{kind: uvs_pkg::KIND_TEX,
                             x: r_c_side.tex_u,
                             y: r_c_side.tex_v,
                             z: 32'd0};
            n_set.ent[3] = '{kind: uvs_pkg::KIND_TAN,
                             x: rnd_sat(66'(r_c_ct), SH_Q),
                             y: 32'd0,
                             z: rnd_sat(-66'(r_c_st), SH_Q)};
            n_set.ent[4] = '{kind: uvs_pkg::KIND_BIN,
                             x: rnd_sat(66'(r_c_bx), SH_Q),
                             y: rnd_sat(66'(r_c_sp), SH_Q),
                             z: rnd_sat(66'(r_c_bz), SH_Q)};
        end
    end

    assign o_valid = r_c_valid;
    assign o_set   = n_set;

endmodule

@@ rtl/core/uvs_serializer.sv @@
// ----------------------------------------------------------------------------
// uvs_serializer
// Holds one item's result set and hands it out one beat per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvs_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  uvs_pkg::t_res_set  i_set,
    input  logic               i_out_stall,
    output logic               o_free,
    output logic               o_out_valid,
    output uvs_pkg::t_out_beat o_out_data
);

    logic              r_valid;
    logic [2:0]        r_idx;
    uvs_pkg::t_res_set r_set;
    logic              take;
    logic              at_last;
    uvs_pkg::t_res     cur;

    assign at_last = (r_idx == r_set.cnt - 3'd1);
    assign take    = r_valid && !i_out_stall;
    assign o_free  = !r_valid || (take && at_last);
    assign cur     = r_set.ent[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take && at_last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_out_data.kind   = cur.kind;
    assign o_out_data.comp_x = cur.x;
    assign o_out_data.comp_y = cur.y;
    assign o_out_data.comp_z = cur.z;
    assign o_out_data.last   = at_last;

endmodule

@@ rtl/core/uvs_checker.sv @@
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the UV sphere vertex generator's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input uvs_pkg::t_out_beat o_out_data
);

    // a stalled result beat stays put
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result beat changed")

    // an invalid beat is alone and carries zeros
    `CHK_IMPL(a_inv_beat, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == uvs_pkg::KIND_INV), o_out_data.last && (o_out_data.comp_x == 0) && (o_out_data.comp_y == 0) && (o_out_data.comp_z == 0), "invalid beat malformed")

    // a taken position beat is followed at once by the normal
    `CHK_NEXT(a_pos_next, i_clk, i_rst_n, o_out_valid && !i_out_stall && (o_out_data.kind == uvs_pkg::KIND_POS), o_out_valid && (o_out_data.kind == uvs_pkg::KIND_NORM), "normal does not follow position")

    // binormal closes a vertex, texcoord does not and has no third component
    `CHK_IMPL(a_bin_last, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == uvs_pkg::KIND_BIN), o_out_data.last, "binormal beat not last")

    `CHK_IMPL(a_tex_beat, i_clk, i_rst_n, o_out_valid && (o_out_data.kind == uvs_pkg::KIND_TEX), !o_out_data.last && (o_out_data.comp_z == 0), "texcoord beat malformed")

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (.*);

@@ verif/tb_uv_sphere_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator
// Checks every result beat of the UV sphere generator against a bit-exact
// model of its angle division, CORDIC and fixed-point rounding, under several
// resolution and radius settings and random idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;

    localparam int  FRAC      = uvs_pkg::FRAC_BITS_DEF;
    localparam int  STAGES    = uvs_pkg::CORDIC_STAGES_DEF;
    localparam int  WDOG_MAX  = 20000;
    localparam int  DRAIN_CYC = 200;
    // index with no register behind it
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    uvs_pkg::t_in_beat  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    uvs_pkg::t_out_beat out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    uv_sphere_vertex_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // mirrored register state
    longint    theta_steps = 32;
    longint    phi_steps = 16;
    longint    radius = 65536;

    uvs_pkg::t_out_beat expected_beats[$];
    int        mismatches = 0;
    int        errors = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        idle_cnt = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint atan_entry(int i);
        longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return tab[i];
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint z, x, y, dx, dy;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang = ang - 32'h8000_0000;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic uvs_pkg::t_out_beat mk(logic [2:0] k, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z, logic l);
        uvs_pkg::t_out_beat b;
        b.kind = k; b.comp_x = x; b.comp_y = y; b.comp_z = z; b.last = l;
        return b;
    endfunction

    function automatic logic [31:0] q30o(longint v);
        return sat32(rnd(v, 30 - FRAC));
    endfunction

    function automatic logic [31:0] rado(longint v);
        return sat32(rnd(radius * v, 46 - FRAC));
    endfunction

    task automatic predict_mesh(input uvs_pkg::t_in_beat it);
        longint t, p, base, ct, st, cp, sp, bx, by, bz, u, v;
        logic [31:0] ta, pa;
        logic ok;
        t = theta_steps;
        p = phi_steps;
        ok = t >= 2 && t <= uvs_pkg::MAX_RES_DEF && p >= 2 && p <= uvs_pkg::MAX_RES_DEF;
        if (it.func) begin
            if (!ok || it.ring >= p - 1 || it.segment >= t - 1) begin
                expected_beats.push_back(mk(uvs_pkg::KIND_INV, 0, 0, 0, 1'b1));
                return;
            end
            base = t * it.ring + it.segment;
            expected_beats.push_back(mk(uvs_pkg::KIND_TRI, 32'(base), 32'(base + 1),
                                        32'(base + 1 + t), 1'b0));
            expected_beats.push_back(mk(uvs_pkg::KIND_TRI, 32'(base), 32'(base + t + 1),
                                        32'(base + t), 1'b1));
        end else begin
            if (!ok || it.ring >= p || it.segment >= t) begin
                expected_beats.push_back(mk(uvs_pkg::KIND_INV, 0, 0, 0, 1'b1));
                return;
            end
            ta = 32'((longint'(it.segment) << 32) / (t - 1));
            pa = 32'((longint'(it.ring) << 31) / (p - 1));
            rotate(ta, ct, st);
            rotate(pa, cp, sp);
            bx = rnd(st * cp, 30);
            by = sp;
            bz = rnd(ct * cp, 30);
            expected_beats.push_back(mk(uvs_pkg::KIND_POS, rado(rnd(st * sp, 30)), rado(-cp),
                                        rado(rnd(ct * sp, 30)), 1'b0));
            expected_beats.push_back(mk(uvs_pkg::KIND_NORM, q30o(rnd(st * by, 30)),
                                        q30o(rnd(-st * bx - ct * bz, 30)),
                                        q30o(rnd(ct * by, 30)), 1'b0));
            u = ((longint'(it.segment) << (FRAC + 1)) + (t - 1)) / ((t - 1) * 2);
            v = ((longint'(it.ring) << (FRAC + 1)) + (p - 1)) / ((p - 1) * 2);
            expected_beats.push_back(mk(uvs_pkg::KIND_TEX, sat32(u), sat32(v), 0, 1'b0));
            expected_beats.push_back(mk(uvs_pkg::KIND_TAN, q30o(ct), 0, q30o(-st), 1'b0));
            expected_beats.push_back(mk(uvs_pkg::KIND_BIN, q30o(bx), q30o(by), q30o(bz),
                                        1'b1));
        end
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        uvs_pkg::t_out_beat exp_b;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_beats.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected beat %p", out_data);
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (exp_b !== out_data) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: exp %p got %p", exp_b, out_data);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high after the accepting edge until the next item or an idle
    // cycle drives it
    task automatic send_item(input uvs_pkg::t_in_beat it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_mesh(it);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == uvs_pkg::CFG_THETA) theta_steps = val[10:0];
        else if (idx == uvs_pkg::CFG_PHI) phi_steps = val[10:0];
        else if (idx == uvs_pkg::CFG_RADIUS) radius = val;
    endtask

    function automatic uvs_pkg::t_in_beat item(logic f, int r, int s);
        uvs_pkg::t_in_beat b;
        b.func = f; b.ring = 10'(r); b.segment = 10'(s);
        return b;
    endfunction

    task automatic test_directed();
        send_item(item(0, 0, 0));
        send_item(item(0, 15, 31));
        send_item(item(0, 7, 8));
        send_item(item(0, 8, 16));
        send_item(item(0, 5, 24));
        send_item(item(1, 0, 0));
        send_item(item(1, 14, 30));
        send_item(item(1, 15, 0));     // quad past last ring
        send_item(item(1, 0, 31));     // quad past last segment
        send_item(item(0, 16, 0));     // ring out of range
        send_item(item(0, 0, 32));
        send_item(item(0, 1023, 1023));
        send_item(item(1, 1023, 1023));
        write_reg(uvs_pkg::CFG_RADIUS, 24'd0);  // zero radius
        send_item(item(0, 3, 5));
        write_reg(uvs_pkg::CFG_RADIUS, 24'hFF_FFFF);
        send_item(item(0, 3, 5));
        send_item(item(0, 9, 27));
        write_reg(uvs_pkg::CFG_THETA, 24'd1);   // bad resolution
        send_item(item(0, 0, 0));
        send_item(item(1, 0, 0));
        write_reg(uvs_pkg::CFG_THETA, 24'd1025);
        send_item(item(0, 1, 1));
        write_reg(uvs_pkg::CFG_THETA, 24'h7FF);
        send_item(item(1, 0, 0));
    endtask

    task automatic random_phase(int n, int t, int p, int r);
        uvs_pkg::t_in_beat b;
        write_reg(uvs_pkg::CFG_THETA, 24'(t));
        write_reg(uvs_pkg::CFG_PHI, 24'(p));
        write_reg(uvs_pkg::CFG_RADIUS, 24'(r));
        for (int i = 0; i < n; i++) begin
            b.func = 1'($urandom_range(1));
            if ($urandom_range(9) < 8) begin
                b.ring    = 10'($urandom_range(p - 1));
                b.segment = 10'($urandom_range(t - 1));
            end else begin
                b.ring    = 10'($urandom_range(1023));
                b.segment = 10'($urandom_range(1023));
            end
            send_item(b);
        end
    endtask

    task automatic test_random();
        send_idle_pct = 0;  stall_pct = 0;
        random_phase(20, 2, 2, 65536);
        send_idle_pct = 58; stall_pct = 0;
        random_phase(20, 1024, 1024, $urandom_range(24'hFF_FFFF));
        send_idle_pct = 0;  stall_pct = 58;
        random_phase(20, $urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(1 << 20));
        send_idle_pct = 31; stall_pct = 31;
        random_phase(20, $urandom_range(2, 1024), $urandom_range(2, 1024),
                     $urandom_range(24'hFF_FFFF));
        send_idle_pct = 0;  stall_pct = 0;
        write_reg(CFG_UNMAPPED, 24'h123456);   // ignored
        random_phase(5, 32, 16, 65536);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait_drain();
        if (errors == 0 && expected_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
